// ===== rtl/core/bled_pkg.sv =====
// Shared types, constants and helper functions of the button ladder event detector.
`timescale 1ns / 1ps
package bled_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TIME_BITS   = 32;
    localparam int TOL_W       = 12;
    localparam int MS_W        = 16;
    localparam int BTN_W       = 3;
    localparam int EV_W        = 3;
    localparam int FEAT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Sum of three samples, and three times (level + tolerance).
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int THR_W = ((SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W) + 3;

    localparam int LVL_RIGHT    = 3;
    localparam int LVL_LEFT     = 1470;
    localparam int LVL_CONFIRM  = 2655;
    localparam int LVL_BACK     = 3470;
    localparam int LVL_VOL_DOWN = 3;
    localparam int LVL_VOL_UP   = 2205;

    localparam logic [BTN_W-1:0] KEY_NONE     = 3'd0;
    localparam logic [BTN_W-1:0] KEY_RIGHT    = 3'd1;
    localparam logic [BTN_W-1:0] KEY_LEFT     = 3'd2;
    localparam logic [BTN_W-1:0] KEY_CONFIRM  = 3'd3;
    localparam logic [BTN_W-1:0] KEY_BACK     = 3'd4;
    localparam logic [BTN_W-1:0] KEY_VOL_DOWN = 3'd5;
    localparam logic [BTN_W-1:0] KEY_VOL_UP   = 3'd6;
    localparam logic [BTN_W-1:0] KEY_POWER    = 3'd7;

    localparam int FEAT_SETTLE = 0;
    localparam int FEAT_LONG   = 1;
    localparam int FEAT_REPEAT = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd6;

    typedef enum logic [EV_W-1:0] {
        EV_PRESSED  = 3'd0,
        EV_RELEASED = 3'd1,
        EV_LONG     = 3'd2,
        EV_REPEAT   = 3'd3,
        EV_DOUBLE   = 3'd4
    } t_event;

    typedef struct packed {
        logic [FEAT_W-1:0] features;
        logic [MS_W-1:0]   settle_ms;
        logic [MS_W-1:0]   long_hold_ms;
        logic [MS_W-1:0]   first_repeat_ms;
        logic [MS_W-1:0]   repeat_period_ms;
        logic [MS_W-1:0]   double_click_ms;
        logic [TOL_W-1:0]  level_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [BTN_W-1:0] button_id;
        t_event           event_code;
        logic             last_of_run;
    } t_result;

    // Up to two results produced by one request.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_track_out;

    // Three times (level + tolerance): the sample sum lies below this exactly
    // when the truncated average lies below level + tolerance.
    function automatic logic [THR_W-1:0] lvl_thr(input int level,
                                                 input logic [TOL_W-1:0] tol);
        logic [THR_W-1:0] x;
        x = THR_W'(level) + THR_W'(tol);
        return x + (x << 1);
    endfunction

endpackage

// ===== rtl/core/bled_cfg_regs.sv =====
// Configuration register file of the button ladder event detector.
`timescale 1ns / 1ps
module bled_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bled_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bled_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output bled_pkg::t_cfg                     o_cfg
);

    bled_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.features         <= bled_pkg::FEAT_W'(7);
            r_cfg.settle_ms        <= bled_pkg::MS_W'(20);
            r_cfg.long_hold_ms     <= bled_pkg::MS_W'(1000);
            r_cfg.first_repeat_ms  <= bled_pkg::MS_W'(500);
            r_cfg.repeat_period_ms <= bled_pkg::MS_W'(100);
            r_cfg.double_click_ms  <= bled_pkg::MS_W'(300);
            r_cfg.level_tolerance  <= bled_pkg::TOL_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bled_pkg::CFG_FEATURES: begin
                    r_cfg.features <= i_cfg_wdata[bled_pkg::FEAT_W-1:0];
                end
                bled_pkg::CFG_SETTLE: begin
                    r_cfg.settle_ms <= i_cfg_wdata[bled_pkg::MS_W-1:0];
                end
                bled_pkg::CFG_LONG_PRESS: begin
                    r_cfg.long_hold_ms <= i_cfg_wdata[bled_pkg::MS_W-1:0];
                end
                bled_pkg::CFG_FIRST_REPEAT: begin
                    r_cfg.first_repeat_ms <= i_cfg_wdata[bled_pkg::MS_W-1:0];
                end
                bled_pkg::CFG_REPEAT_PERIOD: begin
                    r_cfg.repeat_period_ms <= i_cfg_wdata[bled_pkg::MS_W-1:0];
                end
                bled_pkg::CFG_DOUBLE_CLICK: begin
                    r_cfg.double_click_ms <= i_cfg_wdata[bled_pkg::MS_W-1:0];
                end
                bled_pkg::CFG_TOLERANCE: begin
                    r_cfg.level_tolerance <= i_cfg_wdata[bled_pkg::TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bled_decode.sv =====
// Ladder decoder: averages each channel and maps it to a button code.
`timescale 1ns / 1ps
module bled_decode (
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_a_s0,
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_a_s1,
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_a_s2,
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_b_s0,
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_b_s1,
    input  logic [bled_pkg::SAMPLE_BITS-1:0] i_b_s2,
    input  logic                             i_power_pin,
    input  logic [bled_pkg::TOL_W-1:0]       i_tol,
    output logic [bled_pkg::BTN_W-1:0]       o_button
);

    logic [bled_pkg::THR_W-1:0] sum_a;
    logic [bled_pkg::THR_W-1:0] sum_b;

    // Compare the sum against three times the threshold instead of dividing.
    assign sum_a = bled_pkg::THR_W'(i_a_s0) + bled_pkg::THR_W'(i_a_s1)
                 + bled_pkg::THR_W'(i_a_s2);
    assign sum_b = bled_pkg::THR_W'(i_b_s0) + bled_pkg::THR_W'(i_b_s1)
                 + bled_pkg::THR_W'(i_b_s2);

    always_comb begin
        if (!i_power_pin) begin
            o_button = bled_pkg::KEY_POWER;
        end else if (sum_a < bled_pkg::lvl_thr(bled_pkg::LVL_RIGHT, i_tol)) begin
            o_button = bled_pkg::KEY_RIGHT;
        end else if (sum_a < bled_pkg::lvl_thr(bled_pkg::LVL_LEFT, i_tol)) begin
            o_button = bled_pkg::KEY_LEFT;
        end else if (sum_a < bled_pkg::lvl_thr(bled_pkg::LVL_CONFIRM, i_tol)) begin
            o_button = bled_pkg::KEY_CONFIRM;
        end else if (sum_a < bled_pkg::lvl_thr(bled_pkg::LVL_BACK, i_tol)) begin
            o_button = bled_pkg::KEY_BACK;
        end else if (sum_b < bled_pkg::lvl_thr(bled_pkg::LVL_VOL_DOWN, i_tol)) begin
            o_button = bled_pkg::KEY_VOL_DOWN;
        end else if (sum_b < bled_pkg::lvl_thr(bled_pkg::LVL_VOL_UP, i_tol)) begin
            o_button = bled_pkg::KEY_VOL_UP;
        end else begin
            o_button = bled_pkg::KEY_NONE;
        end
    end

endmodule

// ===== rtl/core/bled_tracker.sv =====
// Press tracker: holds button state and turns decoded buttons into events.
`timescale 1ns / 1ps
module bled_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic [bled_pkg::BTN_W-1:0]       i_button,
    input  logic [bled_pkg::TIME_BITS-1:0]   i_now,
    input  bled_pkg::t_cfg                   i_cfg,
    output bled_pkg::t_track_out             o_track
);

    logic                           r_held_flag,   n_held_flag;
    logic                           r_pending,     n_pending;
    logic                           r_long_done,   n_long_done;
    logic                           r_rep_started, n_rep_started;
    logic [bled_pkg::BTN_W-1:0]     r_held_btn,    n_held_btn;
    logic [bled_pkg::TIME_BITS-1:0] r_press_start, n_press_start;
    logic [bled_pkg::TIME_BITS-1:0] r_last_event,  n_last_event;
    logic [bled_pkg::TIME_BITS-1:0] r_last_rel,    n_last_rel;
    logic [bled_pkg::BTN_W-1:0]     r_last_rel_btn, n_last_rel_btn;

    logic [bled_pkg::TIME_BITS-1:0] d_press;
    logic [bled_pkg::TIME_BITS-1:0] d_event;
    logic [bled_pkg::TIME_BITS-1:0] d_rel;
    logic [bled_pkg::MS_W-1:0]      rep_wait;
    logic                           fire_long;
    logic                           fire_rep;

    assign d_press  = i_now - r_press_start;
    assign d_event  = i_now - r_last_event;
    assign d_rel    = i_now - r_last_rel;
    assign rep_wait = r_rep_started ? i_cfg.repeat_period_ms : i_cfg.first_repeat_ms;

    assign fire_long = i_cfg.features[bled_pkg::FEAT_LONG] && !r_long_done
                     && (d_press >= bled_pkg::TIME_BITS'(i_cfg.long_hold_ms));
    assign fire_rep  = i_cfg.features[bled_pkg::FEAT_REPEAT]
                     && (d_event >= bled_pkg::TIME_BITS'(rep_wait));

    always_comb begin
        n_held_flag    = r_held_flag;
        n_pending      = r_pending;
        n_long_done    = r_long_done;
        n_rep_started  = r_rep_started;
        n_held_btn     = r_held_btn;
        n_press_start  = r_press_start;
        n_last_event   = r_last_event;
        n_last_rel     = r_last_rel;
        n_last_rel_btn = r_last_rel_btn;

        o_track.count          = 2'd0;
        o_track.r0.button_id   = r_held_btn;
        o_track.r0.event_code  = bled_pkg::EV_PRESSED;
        o_track.r0.last_of_run = 1'b1;
        o_track.r1.button_id   = i_button;
        o_track.r1.event_code  = bled_pkg::EV_REPEAT;
        o_track.r1.last_of_run = 1'b1;

        if (i_fire) begin
            if (r_pending) begin
                // Resolve the pending press once the settle time has gone by.
                if (d_press >= bled_pkg::TIME_BITS'(i_cfg.settle_ms)) begin
                    n_pending = 1'b0;
                    if (i_button == r_held_btn) begin
                        o_track.count = 2'd1;
                    end else begin
                        n_held_flag = 1'b0;
                        n_held_btn  = bled_pkg::KEY_NONE;
                    end
                end
            end else if (i_button == bled_pkg::KEY_NONE) begin
                if (r_held_flag) begin
                    o_track.count = 2'd1;
                    if (d_rel <= bled_pkg::TIME_BITS'(i_cfg.double_click_ms)
                        && r_held_btn == r_last_rel_btn && !r_long_done) begin
                        o_track.r0.event_code = bled_pkg::EV_DOUBLE;
                        n_last_rel     = '0;
                        n_last_rel_btn = bled_pkg::KEY_NONE;
                    end else begin
                        o_track.r0.event_code = bled_pkg::EV_RELEASED;
                        n_last_rel     = i_now;
                        n_last_rel_btn = r_held_btn;
                    end
                    n_held_flag   = 1'b0;
                    n_long_done   = 1'b0;
                    n_rep_started = 1'b0;
                    n_held_btn    = bled_pkg::KEY_NONE;
                end
            end else if (!r_held_flag) begin
                n_held_btn    = i_button;
                n_held_flag   = 1'b1;
                n_press_start = i_now;
                n_last_event  = i_now;
                o_track.r0.button_id = i_button;
                if (i_cfg.features[bled_pkg::FEAT_SETTLE]) begin
                    n_pending = 1'b1;
                end else begin
                    o_track.count = 2'd1;
                end
            end else begin
                o_track.r0.button_id = i_button;
                if (fire_long) begin
                    n_long_done = 1'b1;
                end
                if (fire_rep) begin
                    n_rep_started = 1'b1;
                    n_last_event  = i_now;
                end
                // Long press goes first when both fire.
                if (fire_long && fire_rep) begin
                    o_track.count          = 2'd2;
                    o_track.r0.event_code  = bled_pkg::EV_LONG;
                    o_track.r0.last_of_run = 1'b0;
                end else if (fire_long) begin
                    o_track.count         = 2'd1;
                    o_track.r0.event_code = bled_pkg::EV_LONG;
                end else if (fire_rep) begin
                    o_track.count         = 2'd1;
                    o_track.r0.event_code = bled_pkg::EV_REPEAT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_flag    <= 1'b0;
            r_pending      <= 1'b0;
            r_long_done    <= 1'b0;
            r_rep_started  <= 1'b0;
            r_held_btn     <= bled_pkg::KEY_NONE;
            r_press_start  <= '0;
            r_last_event   <= '0;
            r_last_rel     <= '0;
            r_last_rel_btn <= bled_pkg::KEY_NONE;
        end else begin
            r_held_flag    <= n_held_flag;
            r_pending      <= n_pending;
            r_long_done    <= n_long_done;
            r_rep_started  <= n_rep_started;
            r_held_btn     <= n_held_btn;
            r_press_start  <= n_press_start;
            r_last_event   <= n_last_event;
            r_last_rel     <= n_last_rel;
            r_last_rel_btn <= n_last_rel_btn;
        end
    end

endmodule

// ===== rtl/core/bled_out_fifo.sv =====
// Four-entry result queue: takes up to two results a cycle, hands out one unless stalled.
`timescale 1ns / 1ps
module bled_out_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bled_pkg::t_track_out   i_push,
    output logic                   o_room,
    output logic                   o_valid,
    input  logic                   i_stall,
    output bled_pkg::t_result      o_result
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    bled_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    // Room for the largest burst of one request.
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && !i_stall;
    assign o_result = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(i_push.count);
        n_rptr  = r_rptr + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wptr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wptr + PTR_W'(1)] <= i_push.r1;
        end
    end

endmodule

// ===== rtl/core/button_ladder_event_detector_core.sv =====
// Top level of the button ladder event detector.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one poll request: a ms
//   timestamp, three samples of each ladder channel and the power pin level.
//   The ladders are decoded as the request is taken and the decoded button is
//   held in the input register together with the timestamp.
//   Output channel (o_out_valid / i_out_stall) carries the events, one per
//   request of the output channel; a poll causes zero, one or two events and
//   the last one of each poll carries o_last_of_run.
//   Order: a poll is held in the input register; the tracker processes it
//   once the result queue has room and writes its events into the queue,
//   from which they are offered on the output.
//   Throughput: one poll per cycle while polls give at most one event each
//   and the receiver does not stall. The four-entry result queue sets this
//   figure.
//   Stalling: when the receiver stalls the queue fills; the tracker only
//   processes a poll while two queue entries are free, and the input stall
//   rises while the held poll cannot be processed. Nothing is dropped.
//   Reset (i_rst_n low, synchronous): clear tracker state, empty the queue and
//   load the register defaults. Configuration writes (i_cfg_we) are taken
//   every cycle and are meant to be made while the block is idle.
module button_ladder_event_detector_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bled_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bled_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [31:0]                        i_now_ms,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_a_s0,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_a_s1,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_a_s2,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_b_s0,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_b_s1,
    input  logic [bled_pkg::SAMPLE_BITS-1:0]   i_ladder_b_s2,
    input  logic                               i_power_pin,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bled_pkg::BTN_W-1:0]         o_button_id,
    output logic [bled_pkg::EV_W-1:0]          o_event_code,
    output logic                               o_last_of_run
);

    bled_pkg::t_cfg                 cfg;
    bled_pkg::t_track_out           track;
    bled_pkg::t_result              result;
    logic [bled_pkg::BTN_W-1:0]     dec_button;
    logic                           accept;
    logic                           fire;
    logic                           room;

    // Input register: decoded button and timestamp of the waiting request.
    logic                           r_in_vld;
    logic [bled_pkg::BTN_W-1:0]     r_in_btn;
    logic [bled_pkg::TIME_BITS-1:0] r_in_now;

    bled_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bled_decode u_decode (
        .i_a_s0      (i_ladder_a_s0),
        .i_a_s1      (i_ladder_a_s1),
        .i_a_s2      (i_ladder_a_s2),
        .i_b_s0      (i_ladder_b_s0),
        .i_b_s1      (i_ladder_b_s1),
        .i_b_s2      (i_ladder_b_s2),
        .i_power_pin (i_power_pin),
        .i_tol       (cfg.level_tolerance),
        .o_button    (dec_button)
    );

    // Process the held request when the queue can take a full burst.
    assign fire       = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_btn <= dec_button;
            r_in_now <= bled_pkg::TIME_BITS'(i_now_ms);
        end
    end

    bled_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_button (r_in_btn),
        .i_now    (r_in_now),
        .i_cfg    (cfg),
        .o_track  (track)
    );

    bled_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (track),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_button_id   = result.button_id;
    assign o_event_code  = result.event_code;
    assign o_last_of_run = result.last_of_run;

endmodule
